// ===== hw/rtl/mersenne_twister_prng_defines.svh =====
`ifndef MERSENNE_TWISTER_PRNG_DEFINES_SVH
`define MERSENNE_TWISTER_PRNG_DEFINES_SVH

// same-cycle implication, off during reset
`define MTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtp check failed");

// next-cycle implication, off during reset
`define MTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtp check failed");

`endif

// ===== hw/rtl/mtp_pkg.sv =====
package mtp_pkg;

  localparam int STATE_WORDS = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int IDX_W       = $clog2(STATE_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] TAP_FWD    = IDX_W'(TAP_OFFSET);
  localparam logic [IDX_W-1:0] TAP_BACK   = IDX_W'(STATE_WORDS - TAP_OFFSET);

  localparam logic [31:0] SEED_RESET   = 32'd5489;
  localparam logic [31:0] INIT_MULT    = 32'h6c07_8965;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;

  function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] tap);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = tap ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mersenne_twister_prng.sv =====
// channel   signals                      direction  beat
// in        in_valid, in_stall, draw     input      one draw request
// out       out_valid, out_stall, number output     one tempered word
// cfg       cfg_valid, cfg_ready, seed   input      one seed write
//
// a draw does one read of the state memory, then one twist-and-write of the
// drawn word, in a single read-modify-write pass through the memory
// the first draw after reset or a seed write first fills the table, with one
// 32x32 multiply and one add per word
// reset clears control only; the table holds nothing until the first fill
// a held result does not block acceptance; the next word waits on out_stall
// a pending seed write holds off draws until it is taken
module mersenne_twister_prng (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL_MUL,
    S_FILL_ADD,
    S_RUN
  } state_t;

  state_t                        state;
  logic [mtp_pkg::IDX_W-1:0]     position;
  logic [mtp_pkg::IDX_W-1:0]     fill_index;
  logic                          needs_fill;
  logic [31:0]                   seed_word;
  logic [31:0]                   prev;
  logic [31:0]                   prod;
  logic [31:0]                   cur;

  logic [31:0]                   mem [mtp_pkg::STATE_WORDS];
  logic [31:0]                   rd_next;
  logic [31:0]                   rd_tap;
  logic [mtp_pkg::IDX_W-1:0]     next_addr;
  logic [mtp_pkg::IDX_W-1:0]     tap_addr;

  logic                          wr_en;
  logic [mtp_pkg::IDX_W-1:0]     wr_addr;
  logic [31:0]                   wr_data;

  logic                          in_take;
  logic                          out_free;
  logic [31:0]                   fill_word;
  logic [31:0]                   twisted;

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_take   = in_valid && !in_stall && draw;
  assign out_free  = !out_valid || !out_stall;

  assign next_addr = (position == mtp_pkg::LAST_IDX) ? '0 : position + 1'b1;
  assign tap_addr  = (position < mtp_pkg::TAP_BACK) ? position + mtp_pkg::TAP_FWD
                                                    : position - mtp_pkg::TAP_BACK;

  assign fill_word = prod + {{(32 - mtp_pkg::IDX_W){1'b0}}, fill_index};
  assign twisted   = mtp_pkg::twist_word(cur, rd_next, rd_tap);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = position;
    wr_data = twisted;
    case (state)
      S_IDLE: begin
        wr_en   = in_take && needs_fill;
        wr_addr = '0;
        wr_data = seed_word;
      end
      S_FILL_ADD: begin
        wr_en   = 1'b1;
        wr_addr = fill_index;
        wr_data = fill_word;
      end
      S_RUN: begin
        wr_en = out_free;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_next <= mem[next_addr];
    rd_tap  <= mem[tap_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      position   <= '0;
      needs_fill <= 1'b1;
      seed_word  <= mtp_pkg::SEED_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RUN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            seed_word  <= seed;
            needs_fill <= 1'b1;
          end else if (in_take) begin
            if (needs_fill) begin
              prev       <= seed_word;
              cur        <= seed_word;
              fill_index <= mtp_pkg::IDX_W'(1);
              position   <= '0;
              state      <= S_FILL_MUL;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_FILL_MUL: begin
          prod  <= mtp_pkg::INIT_MULT * (prev ^ (prev >> 30));
          state <= S_FILL_ADD;
        end
        S_FILL_ADD: begin
          prev       <= fill_word;
          fill_index <= fill_index + 1'b1;
          if (fill_index == mtp_pkg::LAST_IDX) begin
            needs_fill <= 1'b0;
            state      <= S_RUN;
          end else begin
            state <= S_FILL_MUL;
          end
        end
        S_RUN: begin
          if (out_free) begin
            cur       <= rd_next;
            number    <= mtp_pkg::temper(twisted);
            out_valid <= 1'b1;
            position  <= next_addr;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mtp_check.sv =====
`include "mersenne_twister_prng_defines.svh"

module mtp_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        draw,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] number,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `MTP_ASSERT_NXT(held_result_stays, out_valid && out_stall, out_valid && $stable(number))
  `MTP_ASSERT_NXT(draw_busies_input, in_valid && !in_stall && draw, in_stall)
  `MTP_ASSERT_IMP(seed_holds_off_draws, cfg_valid && cfg_ready, in_stall)
  `MTP_ASSERT_IMP(result_follows_work, $rose(out_valid), $past(in_stall))

endmodule

bind mersenne_twister_prng mtp_check u_mtp_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .draw      (draw),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .number    (number),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== bench/tb_mersenne_twister_prng.sv =====
module tb_mersenne_twister_prng;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS = 624;
  localparam int TAP = 397;
  localparam logic [31:0] FILL_MULT = 32'h6c07_8965;
  localparam logic [31:0] MATRIX_A = 32'h9908_b0df;
  localparam logic [31:0] MASK_B = 32'h9d2c_5680;
  localparam logic [31:0] MASK_C = 32'hefc6_0000;
  localparam logic [31:0] UPPER_BIT = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        draw;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] number;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] seed;

  logic [31:0] mt_words [WORDS];
  int unsigned word_pos;
  bit          refill_pending;
  logic [31:0] seed_shadow;
  logic [31:0] pending_words [$];
  int unsigned errors;
  bit          in_burst;
  bit          out_burst;

  mersenne_twister_prng dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .draw     (draw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .number   (number),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .seed     (seed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_mersenne_twister_prng NOT OK");
    $finish;
  end

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & MASK_B);
    t = t ^ ((t << 15) & MASK_C);
    return t ^ (t >> 18);
  endfunction

  function automatic void fill_from_seed();
    logic [31:0] prev;
    mt_words[0] = seed_shadow;
    for (int i = 1; i < WORDS; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = FILL_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
  endfunction

  function automatic void twist_words();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < WORDS; i++) begin
      y = (mt_words[i] & UPPER_BIT) | (mt_words[(i + 1) % WORDS] & LOWER_BITS);
      v = mt_words[(i + TAP) % WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MATRIX_A;
      end
      mt_words[i] = v;
    end
  endfunction

  function automatic logic [31:0] predict_draw();
    logic [31:0] w;
    if (refill_pending) begin
      fill_from_seed();
      word_pos = WORDS;
      refill_pending = 1'b0;
    end
    if (word_pos >= WORDS) begin
      twist_words();
      word_pos = 0;
    end
    w = temper_word(mt_words[word_pos]);
    word_pos++;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTED) begin
      $display("%0t %s: got %08h want %08h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // result side: random stall per beat, bursts with none
  initial begin : out_side
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 13);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do begin
        @(posedge clk);
      end while (rst || !(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_words
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with none pending", number, 32'h0);
      end else begin
        want = pending_words.pop_front();
        if (number !== want) begin
          report_mismatch("number", number, want);
        end
      end
    end
  end

  task automatic send_item(input logic want_draw);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    draw = want_draw;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (want_draw) begin
      pending_words.push_back(predict_draw());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    seed = value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    seed_shadow = value;
    refill_pending = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly draws, about one in ten beats a non-request
  task automatic run_draws(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
      end
      send_item($urandom_range(0, 9) != 0);
    end
    in_burst = 1'b0;
    out_burst = 1'b0;
  endtask

  task automatic test_reset_seed();
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_seed_extremes();
    logic [31:0] values [4];
    values = '{32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};
    foreach (values[i]) begin
      write_seed(values[i]);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b1);
    end
  endtask

  task automatic test_reseed_mid_run();
    write_seed(32'd1);
    repeat (3) send_item(1'b1);
    write_seed(32'd1);
    repeat (2) send_item(1'b1);
  endtask

  task automatic test_table_wrap();
    write_seed($urandom());
    run_draws(1350);
  endtask

  task automatic test_random_reseeds();
    repeat (4) begin
      write_seed($urandom_range(0, 1) ? $urandom() : seed_shadow);
      run_draws($urandom_range(20, 60));
    end
    write_seed(DEFAULT_SEED);
    run_draws(30);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    draw = 1'b0;
    cfg_valid = 1'b0;
    seed = '0;
    errors = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    seed_shadow = DEFAULT_SEED;
    word_pos = WORDS;
    refill_pending = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_seed();
    test_seed_extremes();
    test_reseed_mid_run();
    test_table_wrap();
    test_random_reseeds();

    wait_idle();
    if (errors == 0) begin
      $display("tb_mersenne_twister_prng OK");
    end else begin
      $display("tb_mersenne_twister_prng NOT OK");
    end
    $finish;
  end

endmodule
